// ----- src/bca_pkg.sv -----
// Bar column aggregator package: shared types, request and register codes,
// colour table and the serial divider's request/response structs. No dependencies.

package bca_pkg;

    localparam int MAX_MEMBERS  = 4096;
    localparam int MAX_COLUMNS  = 256;
    localparam int MARKER_KINDS = 5;
    localparam int MARK_W       = 8;   // low 8 bits of each column marker count
    localparam int SUM_W        = 45;
    localparam int DIV_NW       = 48;  // dividend / quotient width
    localparam int DIV_DW       = 32;  // divisor width

    // request codes
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_LOAD   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ARRAY_SIZE    = 3'd0;
    localparam logic [2:0] REG_COLUMN_COUNT  = 3'd1;
    localparam logic [2:0] REG_VALUE_MIN     = 3'd2;
    localparam logic [2:0] REG_VALUE_MAX     = 3'd3;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

    localparam logic [7:0] COLOR_NORMAL = 8'h78;

    typedef logic [MARKER_KINDS-1:0][MARK_W-1:0] t_marks;

    // one column entry of the column store
    typedef struct packed {
        logic             dirty;
        t_marks           marks;
        logic [SUM_W-1:0] sum;
    } t_col_word;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

    function automatic logic [7:0] marker_color(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h3C;
            3'd1:    c = 8'h1E;
            3'd2:    c = 8'h4B;
            3'd3:    c = 8'h2E;
            3'd4:    c = 8'h4B;
            default: c = COLOR_NORMAL;
        endcase
        return c;
    endfunction

    // majority marker, later marker wins a tie, normal when all zero
    function automatic logic [7:0] majority_color(input t_marks m);
        logic [MARK_W-1:0] maxc;
        logic [2:0]        best;
        maxc = m[0];
        best = 3'd0;
        for (int k = 1; k < MARKER_KINDS; k++) begin
            if (m[k] >= maxc) begin
                maxc = m[k];
                best = 3'(k);
            end
        end
        return (maxc == '0) ? COLOR_NORMAL : marker_color(best);
    endfunction

endpackage

// ----- src/bca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bca_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bca_pkg (request/response structs, widths).

module bca_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bca_pkg::t_div_req i_req,
    output bca_pkg::t_div_rsp o_rsp
);
    localparam int NW    = bca_pkg::DIV_NW;
    localparam int DW    = bca_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_q, n_q;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_q[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_q    = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_cnt  = CNT_W'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_q   = {r_q[NW-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quot: r_q};

endmodule

// ----- src/bar_column_aggregator_top.sv -----
// Bar column aggregator: an update or load is ready for the next word after its column
// write-back (one 48-step serial division maps the member to its column). A dirty-column
// query uses at most four serial divisions (two column bounds, the average, the height);
// a clean query or an out-of-range column needs none.
// One word in flight at a time, paced by the single shared bit-serial divider. Reset
// (synchronous, active low) loads register defaults and empties columns via valid bits.

module bar_column_aggregator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_position,
    input  logic [7:0]  i_column,
    input  logic        i_set_value,
    input  logic        i_set_marker,
    input  logic        i_add_marker,
    input  logic [2:0]  i_marker,
    input  logic [31:0] i_value,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_need_update,
    output logic [7:0]  o_color_attr,
    output logic [8:0]  o_bar_height
);
    localparam int MAX_MEMBERS = bca_pkg::MAX_MEMBERS;
    localparam int MAX_COLUMNS = bca_pkg::MAX_COLUMNS;
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int MAW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int PW  = CW + 14;
    localparam int NW  = bca_pkg::DIV_NW;
    localparam int DW  = bca_pkg::DIV_DW;
    localparam int SW  = bca_pkg::SUM_W;

    typedef enum logic [4:0] {
        S_IDLE, S_UMUL, S_UDIV, S_URD, S_UWB,
        S_QRD, S_QCHK, S_QF1, S_QF1W, S_QF0, S_QF0W,
        S_QAVG, S_QAVGW, S_QCLMP, S_QMUL, S_QHDIV, S_QOUT
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [12:0] r_asz, n_asz;
    logic [8:0]  r_cols, n_cols;
    logic [31:0] r_vmin, n_vmin;
    logic [31:0] r_vmax, n_vmax;
    logic [8:0]  r_sh, n_sh;
    logic [MAX_COLUMNS-1:0] r_valid, n_valid;

    // latched word
    logic [1:0]    r_req, n_req;
    logic [11:0]   r_pos, n_pos;
    logic [CW-1:0] r_col, n_col;
    logic          r_setv, n_setv;
    logic          r_setm, n_setm;
    logic          r_addm, n_addm;
    logic [2:0]    r_mk, n_mk;
    logic [31:0]   r_val, n_val;

    // working registers
    logic [32:0]   r_delta, n_delta;
    logic [SW-1:0] r_sum, n_sum;
    logic [12:0]   r_f1, n_f1;
    logic [12:0]   r_mem, n_mem;
    logic          r_neg, n_neg;
    logic [31:0]   r_avg, n_avg;
    logic [31:0]   r_absv, n_absv;
    logic [31:0]   r_absmax, n_absmax;
    logic          r_nu, n_nu;
    logic [7:0]    r_color, n_color;
    logic [8:0]    r_height, n_height;

    // divider request
    logic          r_start, n_start;
    logic [NW-1:0] r_num, n_num;
    logic [DW-1:0] r_den, n_den;

    // output slot
    logic       r_o_valid, n_o_valid;
    logic       r_o_nu, n_o_nu;
    logic [7:0] r_o_color, n_o_color;
    logic [8:0] r_o_height, n_o_height;

    // memories
    logic                 w_col_we;
    bca_pkg::t_col_word   w_col_wdata;
    logic [$bits(bca_pkg::t_col_word)-1:0] w_col_rdata;
    logic                 w_mv_we;
    logic [31:0]          w_mv_rdata;

    bca_pkg::t_div_req w_div_req;
    bca_pkg::t_div_rsp w_div_rsp;

    // helpers
    bca_pkg::t_col_word w_word;
    logic [CW:0]   w_cidx;
    logic [PW-1:0] w_cn, w_h, w_x;
    logic [20:0]   w_pm;
    logic [SW-1:0] w_mag;
    logic [NW-1:0] w_qneg;
    logic [31:0]   w_span, w_diff;

    bca_ram #(.WIDTH($bits(bca_pkg::t_col_word)), .DEPTH(MAX_COLUMNS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (r_col),
        .i_wdata (w_col_wdata),
        .i_raddr (r_col),
        .o_rdata (w_col_rdata)
    );

    bca_ram #(.WIDTH(32), .DEPTH(MAX_MEMBERS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_mv_we),
        .i_waddr (MAW'(r_pos)),
        .i_wdata (r_val),
        .i_raddr (MAW'(r_pos)),
        .o_rdata (w_mv_rdata)
    );

    assign w_div_req = '{start: r_start, num: r_num, den: r_den};

    bca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // column count limited to 1..min(MAX_COLUMNS, array size)
    function automatic logic [8:0] clamp_cols(input logic [8:0] v, input logic [12:0] a);
        int cmax;
        int c;
        cmax = (int'(a) < MAX_COLUMNS) ? int'(a) : MAX_COLUMNS;
        c    = (v == '0) ? 1 : int'(v);
        if (c > cmax) c = cmax;
        return 9'(c);
    endfunction

    // shared arithmetic
    always_comb begin
        w_word  = r_valid[r_col] ? bca_pkg::t_col_word'(w_col_rdata) : '0;
        w_pm    = 21'(r_pos) * 21'(r_cols);
        w_cidx  = (r_state == S_QF1) ? ({1'b0, r_col} + (CW+1)'(1)) : {1'b0, r_col};
        w_cn    = PW'(w_cidx) * PW'(r_asz);
        w_h     = PW'(r_cols >> 1);
        w_x     = w_cn + PW'(r_cols) - PW'(1) - w_h;
        w_mag   = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;
        w_qneg  = ~w_div_rsp.quot + NW'(1);
        w_span  = ($signed(r_vmax) <= $signed(r_vmin)) ? 32'd1 : (r_vmax - r_vmin);
        w_diff  = r_avg - r_vmin;
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_asz      = r_asz;
        n_cols     = r_cols;
        n_vmin     = r_vmin;
        n_vmax     = r_vmax;
        n_sh       = r_sh;
        n_valid    = r_valid;
        n_req      = r_req;
        n_pos      = r_pos;
        n_col      = r_col;
        n_setv     = r_setv;
        n_setm     = r_setm;
        n_addm     = r_addm;
        n_mk       = r_mk;
        n_val      = r_val;
        n_delta    = r_delta;
        n_sum      = r_sum;
        n_f1       = r_f1;
        n_mem      = r_mem;
        n_neg      = r_neg;
        n_avg      = r_avg;
        n_absv     = r_absv;
        n_absmax   = r_absmax;
        n_nu       = r_nu;
        n_color    = r_color;
        n_height   = r_height;
        n_start    = 1'b0;
        n_num      = r_num;
        n_den      = r_den;
        n_o_valid  = r_o_valid & ~i_ready;
        n_o_nu     = r_o_nu;
        n_o_color  = r_o_color;
        n_o_height = r_o_height;
        w_col_we    = 1'b0;
        w_col_wdata = w_word;
        w_mv_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req  = i_req_type;
                    n_pos  = i_position;
                    n_col  = CW'(i_column);
                    n_setv = i_set_value;
                    n_setm = i_set_marker;
                    n_addm = i_add_marker;
                    n_mk   = i_marker;
                    n_val  = i_value;
                    case (i_req_type)
                        bca_pkg::REQ_UPDATE, bca_pkg::REQ_LOAD: begin
                            if (({1'b0, i_position} < r_asz)
                                && (int'(i_position) < MAX_MEMBERS)) begin
                                n_state = S_UMUL;
                            end
                        end
                        bca_pkg::REQ_QUERY: begin
                            if ({1'b0, i_column} < r_cols) begin
                                n_state = S_QRD;
                            end else begin
                                n_nu     = 1'b0;
                                n_color  = '0;
                                n_height = '0;
                                n_state  = S_QOUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // column of the member: (pos*C + C/2) / N
            S_UMUL: begin
                n_num   = NW'(w_pm) + NW'(r_cols >> 1);
                n_den   = DW'(r_asz);
                n_start = 1'b1;
                n_state = S_UDIV;
            end
            S_UDIV: begin
                if (w_div_rsp.done) begin
                    n_col   = CW'(w_div_rsp.quot);
                    n_state = S_URD;
                end
            end
            S_URD: begin
                n_delta = {r_val[31], r_val} - {w_mv_rdata[31], w_mv_rdata};
                n_state = S_UWB;
            end
            // column write-back
            S_UWB: begin
                w_col_wdata = w_word;
                if (r_req == bca_pkg::REQ_LOAD) begin
                    w_col_wdata.sum = w_word.sum + {{(SW-32){r_val[31]}}, r_val};
                    w_mv_we = 1'b1;
                end else begin
                    if (r_setm && (int'(r_mk) < bca_pkg::MARKER_KINDS)) begin
                        if (r_addm) begin
                            w_col_wdata.marks[r_mk] = w_word.marks[r_mk] + 8'd1;
                        end else begin
                            w_col_wdata.marks[r_mk] = w_word.marks[r_mk] - 8'd1;
                        end
                    end
                    if (r_setv) begin
                        w_col_wdata.sum = w_word.sum + {{(SW-33){r_delta[32]}}, r_delta};
                        w_mv_we = 1'b1;
                    end
                end
                w_col_wdata.dirty = 1'b1;
                w_col_we          = 1'b1;
                n_valid[r_col]    = 1'b1;
                n_state           = S_IDLE;
            end
            S_QRD: begin
                n_state = S_QCHK;
            end
            // dirty check, clear the flag, pick the colour
            S_QCHK: begin
                if (!w_word.dirty) begin
                    n_nu     = 1'b0;
                    n_color  = '0;
                    n_height = '0;
                    n_state  = S_QOUT;
                end else begin
                    w_col_wdata.dirty = 1'b0;
                    w_col_we          = 1'b1;
                    n_sum             = w_word.sum;
                    n_color           = bca_pkg::majority_color(w_word.marks);
                    n_state           = S_QF1;
                end
            end
            // first member of column c+1: ceil((c'*N - C/2) / C)
            S_QF1: begin
                if (w_cn < w_h) begin
                    n_f1    = '0;
                    n_state = S_QF0;
                end else begin
                    n_num   = NW'(w_x);
                    n_den   = DW'(r_cols);
                    n_start = 1'b1;
                    n_state = S_QF1W;
                end
            end
            S_QF1W: begin
                if (w_div_rsp.done) begin
                    n_f1    = 13'(w_div_rsp.quot);
                    n_state = S_QF0;
                end
            end
            // first member of column c, and from it the member count of column c
            S_QF0: begin
                if (w_cn < w_h) begin
                    n_mem   = r_f1;
                    n_state = S_QAVG;
                end else begin
                    n_num   = NW'(w_x);
                    n_den   = DW'(r_cols);
                    n_start = 1'b1;
                    n_state = S_QF0W;
                end
            end
            S_QF0W: begin
                if (w_div_rsp.done) begin
                    n_mem   = r_f1 - 13'(w_div_rsp.quot);
                    n_state = S_QAVG;
                end
            end
            // signed average, truncated toward zero
            S_QAVG: begin
                if (r_mem == '0) begin
                    n_avg   = '0;
                    n_state = S_QCLMP;
                end else begin
                    n_neg   = r_sum[SW-1];
                    n_num   = NW'(w_mag);
                    n_den   = DW'(r_mem);
                    n_start = 1'b1;
                    n_state = S_QAVGW;
                end
            end
            S_QAVGW: begin
                if (w_div_rsp.done) begin
                    n_avg   = r_neg ? w_qneg[31:0] : w_div_rsp.quot[31:0];
                    n_state = S_QCLMP;
                end
            end
            S_QCLMP: begin
                n_absmax = w_span;
                n_absv   = (w_diff > w_span) ? w_span : w_diff;
                n_state  = S_QMUL;
            end
            S_QMUL: begin
                n_num   = NW'(r_absv) * NW'(r_sh);
                n_den   = r_absmax;
                n_start = 1'b1;
                n_state = S_QHDIV;
            end
            S_QHDIV: begin
                if (w_div_rsp.done) begin
                    n_height = 9'(w_div_rsp.quot);
                    n_nu     = 1'b1;
                    n_state  = S_QOUT;
                end
            end
            // hand the result to the output slot
            S_QOUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_nu     = r_nu;
                    n_o_color  = r_color;
                    n_o_height = r_height;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // register writes (the user must write only while idle; the block does not enforce it)
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bca_pkg::REG_ARRAY_SIZE: begin
                    if (i_cfg_wdata[12:0] == '0) begin
                        n_asz = 13'd1;
                    end else if (int'(i_cfg_wdata[12:0]) > MAX_MEMBERS) begin
                        n_asz = 13'(MAX_MEMBERS);
                    end else begin
                        n_asz = i_cfg_wdata[12:0];
                    end
                    n_cols  = clamp_cols(r_cols, n_asz);
                    n_valid = '0;
                end
                bca_pkg::REG_COLUMN_COUNT: begin
                    n_cols  = clamp_cols(i_cfg_wdata[8:0], r_asz);
                    n_valid = '0;
                end
                bca_pkg::REG_VALUE_MIN: n_vmin = i_cfg_wdata;
                bca_pkg::REG_VALUE_MAX: n_vmax = i_cfg_wdata;
                bca_pkg::REG_SCREEN_HEIGHT: begin
                    if (i_cfg_wdata[8:0] == '0) begin
                        n_sh = 9'd1;
                    end else if (i_cfg_wdata[8:0] > 9'd256) begin
                        n_sh = 9'd256;
                    end else begin
                        n_sh = i_cfg_wdata[8:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_asz     <= 13'd1;
            r_cols    <= 9'd1;
            r_vmin    <= 32'd0;
            r_vmax    <= 32'd1;
            r_sh      <= 9'd25;
            r_valid   <= '0;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_asz     <= n_asz;
            r_cols    <= n_cols;
            r_vmin    <= n_vmin;
            r_vmax    <= n_vmax;
            r_sh      <= n_sh;
            r_valid   <= n_valid;
            r_start   <= n_start;
            r_o_valid <= n_o_valid;
        end
        r_req      <= n_req;
        r_pos      <= n_pos;
        r_col      <= n_col;
        r_setv     <= n_setv;
        r_setm     <= n_setm;
        r_addm     <= n_addm;
        r_mk       <= n_mk;
        r_val      <= n_val;
        r_delta    <= n_delta;
        r_sum      <= n_sum;
        r_f1       <= n_f1;
        r_mem      <= n_mem;
        r_neg      <= n_neg;
        r_avg      <= n_avg;
        r_absv     <= n_absv;
        r_absmax   <= n_absmax;
        r_nu       <= n_nu;
        r_color    <= n_color;
        r_height   <= n_height;
        r_num      <= n_num;
        r_den      <= n_den;
        r_o_nu     <= n_o_nu;
        r_o_color  <= n_o_color;
        r_o_height <= n_o_height;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_need_update = r_o_nu;
    assign o_color_attr  = r_o_color;
    assign o_bar_height  = r_o_height;

    // a new division is never launched over one still running
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // a bar never exceeds the screen height
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bar_height <= r_sh))
        else $error("bar height above screen height");

    // a clean-column answer carries no colour and no height
    a_clean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_need_update) |-> (o_color_attr == '0 && o_bar_height == '0))
        else $error("clean column result not zero");

endmodule
